[hdl/dr_pkg.sv]
package dr_pkg;

    localparam int CMD_W       = 3;
    localparam int IDX_W       = 4;
    localparam int VAL_W       = 16;
    localparam int ACT_W       = 15;
    localparam int ACC_W       = 40;
    localparam int FRAC_BITS   = 8;
    localparam int ROUND_HALF  = 128;
    localparam int ACT_MAX     = 32767;
    localparam int MAX_EMIT    = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_W  = 3'd0,
        CMD_ADD_W = 3'd1,
        CMD_WR_B  = 3'd2,
        CMD_ADD_B = 3'd3,
        CMD_FEED  = 3'd4
    } t_cmd_code;

    typedef enum logic [2:0] {
        OP_WR_W,
        OP_ADD_W,
        OP_WR_B,
        OP_ADD_B,
        OP_FEED
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic                    mac;
        logic                    last;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_W_RD,
        ST_W_WR,
        ST_B_RD,
        ST_B_WR,
        ST_MAC,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

endpackage

[hdl/dr_in_if.sv]
interface dr_in_if;
    import dr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [IDX_W-1:0]        in_index;
    logic [IDX_W-1:0]        out_index;
    logic signed [VAL_W-1:0] value;
    logic                    row_end;

    modport source (
        output valid, command, in_index, out_index, value, row_end,
        input  ready
    );

    modport sink (
        input  valid, command, in_index, out_index, value, row_end,
        output ready
    );
endinterface

[hdl/dr_out_if.sv]
interface dr_out_if;
    import dr_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] neuron;
    logic [ACT_W-1:0] activation;
    logic             final_res;

    modport source (
        output valid, neuron, activation, final_res,
        input  ready
    );

    modport sink (
        input  valid, neuron, activation, final_res,
        output ready
    );
endinterface

[hdl/dr_front.sv]
module dr_front #(
    parameter int IN_SIZE  = 16,
    parameter int OUT_SIZE = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dr_in_if.sink        i_in,
    output dr_pkg::t_job o_job,
    output logic         o_job_vld,
    input  logic         i_job_rdy
);
    import dr_pkg::*;

    logic r_vld;
    t_job r_job;
    t_job job;
    logic keep;
    logic row_ok;
    logic col_ok;
    logic accept;

    assign row_ok = int'(i_in.in_index) < IN_SIZE;
    assign col_ok = int'(i_in.out_index) < OUT_SIZE;

    always_comb begin
        job.row   = i_in.in_index;
        job.col   = i_in.out_index;
        job.value = i_in.value;
        job.mac   = 1'b0;
        job.last  = 1'b0;
        job.op    = OP_FEED;
        keep      = 1'b0;
        case (i_in.command)
            CMD_WR_W: begin
                job.op = OP_WR_W;
                keep   = row_ok && col_ok;
            end
            CMD_ADD_W: begin
                job.op = OP_ADD_W;
                keep   = row_ok && col_ok;
            end
            CMD_WR_B: begin
                job.op = OP_WR_B;
                keep   = col_ok;
            end
            CMD_ADD_B: begin
                job.op = OP_ADD_B;
                keep   = col_ok;
            end
            CMD_FEED: begin
                job.op   = OP_FEED;
                job.mac  = row_ok;
                job.last = i_in.row_end;
                keep     = row_ok || i_in.row_end;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign i_in.ready = !r_vld || i_job_rdy;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= keep;
        end else if (i_job_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= job;
        end
    end

    assign o_job     = r_job;
    assign o_job_vld = r_vld;
endmodule

[hdl/dr_fifo.sv]
module dr_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  dr_pkg::t_job i_job,
    input  logic         i_push_vld,
    output logic         o_push_rdy,
    output dr_pkg::t_job o_job,
    output logic         o_pop_vld,
    input  logic         i_pop_rdy
);
    import dr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_push_rdy = r_cnt != CNT_W'(QUEUE_DEPTH);
    assign o_pop_vld  = r_cnt != '0;
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = o_pop_vld && i_pop_rdy;
    assign o_job      = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end
endmodule

[hdl/dr_back.sv]
module dr_back #(
    parameter int IN_SIZE   = 16,
    parameter int OUT_SIZE  = 16,
    parameter int DATA_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  dr_pkg::t_job i_job,
    input  logic         i_job_vld,
    output logic         o_job_rdy,
    dr_out_if.source     o_out
);
    import dr_pkg::*;

    localparam int OUT_W  = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
    localparam int CNT_W  = $clog2(OUT_SIZE + 1);
    localparam int WDEPTH = IN_SIZE * OUT_SIZE;
    localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int EMIT_N = (OUT_SIZE < MAX_EMIT) ? OUT_SIZE : MAX_EMIT;
    localparam int SW     = ((DATA_BITS > VAL_W) ? DATA_BITS : VAL_W) + 1;
    localparam int PW     = 2 * DATA_BITS;
    localparam int SUMW   = ((PW > ACC_W) ? PW : ACC_W) + 1;
    localparam int TW     = ((ACC_W > DATA_BITS + FRAC_BITS) ? ACC_W
                             : DATA_BITS + FRAC_BITS) + 2;
    localparam longint DMAX = (longint'(1) << (DATA_BITS - 1)) - 1;
    localparam longint DMIN = -DMAX - 1;
    localparam longint AMAX = (longint'(1) << (ACC_W - 1)) - 1;
    localparam longint AMIN = -AMAX - 1;

    // storage
    logic signed [DATA_BITS-1:0] r_wmem [WDEPTH];
    logic signed [DATA_BITS-1:0] r_bmem [OUT_SIZE];
    logic signed [ACC_W-1:0]     r_amem [OUT_SIZE];
    logic [OUT_SIZE-1:0]         r_acc_vld;
    logic signed [DATA_BITS-1:0] r_wrd;
    logic signed [DATA_BITS-1:0] r_brd;
    logic signed [ACC_W-1:0]     r_ard;
    logic                        r_avrd;

    t_state                      r_state;
    t_state                      n_state;
    t_job                        r_job;
    logic signed [DATA_BITS-1:0] r_dval;
    logic [WA_W-1:0]             r_wbase;
    logic [CNT_W-1:0]            r_cnt;

    // MAC pipeline
    logic                        r_s1_vld;
    logic [OUT_W-1:0]            r_s1_idx;
    logic                        r_s2_vld;
    logic [OUT_W-1:0]            r_s2_idx;
    logic signed [PW-1:0]        r_prod;
    logic signed [ACC_W-1:0]     r_s2_acc;

    logic                        r_out_vld;
    logic [IDX_W-1:0]            r_out_neuron;
    logic [ACT_W-1:0]            r_out_act;
    logic                        r_out_fin;

    logic                        take;
    logic                        issue;
    logic                        mac_done;
    logic                        out_free;
    logic                        emit_ld;
    logic                        emit_last;
    logic [OUT_W-1:0]            idx;
    logic [WA_W-1:0]             w_ra;
    logic                        w_we;
    logic signed [DATA_BITS-1:0] w_wd;
    logic [OUT_W-1:0]            b_ra;
    logic                        b_we;
    logic signed [DATA_BITS-1:0] b_wd;
    logic signed [ACC_W-1:0]     a_wd;
    logic signed [TW-1:0]        t_sum;
    logic signed [TW-1:0]        t_shr;
    logic [ACT_W-1:0]            act;

    function automatic logic signed [DATA_BITS-1:0] sat_data(
        input logic signed [SW-1:0] x
    );
        if (longint'(x) > DMAX) begin
            return DATA_BITS'(DMAX);
        end
        if (longint'(x) < DMIN) begin
            return DATA_BITS'(DMIN);
        end
        return DATA_BITS'(x);
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(
        input logic signed [SUMW-1:0] x
    );
        if (x > SUMW'(AMAX)) begin
            return ACC_W'(AMAX);
        end
        if (x < SUMW'(AMIN)) begin
            return ACC_W'(AMIN);
        end
        return ACC_W'(x);
    endfunction

    assign idx       = r_cnt[OUT_W-1:0];
    assign take      = (r_state == ST_IDLE) && i_job_vld;
    assign issue     = (r_state == ST_MAC) && (int'(r_cnt) < OUT_SIZE);
    assign mac_done  = (r_state == ST_MAC) && !issue && !r_s1_vld && !r_s2_vld;
    assign out_free  = !r_out_vld || o_out.ready;
    assign emit_ld   = (r_state == ST_EMIT_LD) && out_free;
    assign emit_last = r_cnt == CNT_W'(EMIT_N - 1);
    assign o_job_rdy = r_state == ST_IDLE;

    always_comb begin
        n_state = r_state;
        w_ra    = r_wbase + WA_W'(r_job.col);
        b_ra    = OUT_W'(r_job.col);
        w_we    = 1'b0;
        b_we    = 1'b0;
        w_wd    = (r_job.op == OP_WR_W) ? r_dval
                  : sat_data(SW'(r_wrd) + SW'(r_job.value));
        b_wd    = (r_job.op == OP_WR_B) ? r_dval
                  : sat_data(SW'(r_brd) + SW'(r_job.value));
        case (r_state)
            ST_IDLE: begin
                if (i_job_vld) begin
                    case (i_job.op)
                        OP_WR_W, OP_ADD_W: n_state = ST_W_RD;
                        OP_WR_B, OP_ADD_B: n_state = ST_B_RD;
                        OP_FEED:           n_state = i_job.mac ? ST_MAC : ST_EMIT_RD;
                        default:           n_state = ST_IDLE;
                    endcase
                end
            end
            ST_W_RD: begin
                n_state = ST_W_WR;
            end
            ST_W_WR: begin
                w_we    = 1'b1;
                n_state = ST_IDLE;
            end
            ST_B_RD: begin
                n_state = ST_B_WR;
            end
            ST_B_WR: begin
                b_we    = 1'b1;
                n_state = ST_IDLE;
            end
            ST_MAC: begin
                w_ra = r_wbase + WA_W'(r_cnt);
                if (mac_done) begin
                    n_state = r_job.last ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                b_ra    = idx;
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                b_ra = idx;
                if (out_free) begin
                    n_state = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job   <= i_job;
            r_dval  <= sat_data(SW'(i_job.value));
            r_wbase <= WA_W'(int'(i_job.row) * OUT_SIZE);
            r_cnt   <= '0;
        end else if (issue || emit_ld) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (mac_done) begin
            r_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_ra] <= w_wd;
        end
        r_wrd <= r_wmem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_bmem[b_ra] <= b_wd;
        end
        r_brd <= r_bmem[b_ra];
    end

    assign a_wd = sat_acc(SUMW'(r_s2_acc) + SUMW'(r_prod));

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_amem[r_s2_idx] <= a_wd;
        end
        r_ard  <= r_amem[idx];
        r_avrd <= r_acc_vld[idx];
    end

    // an accumulator without its valid bit reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
        end else if (emit_ld && emit_last) begin
            r_acc_vld <= '0;
        end else if (r_s2_vld) begin
            r_acc_vld[r_s2_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= idx;
        r_s2_idx <= r_s1_idx;
        r_prod   <= r_dval * r_wrd;
        r_s2_acc <= r_avrd ? r_ard : '0;
    end

    // emission: round to Q8.8, ReLU, saturate
    always_comb begin
        t_sum = TW'(r_avrd ? r_ard : ACC_W'(0)) + (TW'(r_brd) <<< FRAC_BITS)
                + TW'(ROUND_HALF);
        t_shr = t_sum >>> FRAC_BITS;
        if (t_shr < TW'(1)) begin
            act = '0;
        end else if (t_shr > TW'(ACT_MAX)) begin
            act = ACT_W'(ACT_MAX);
        end else begin
            act = t_shr[ACT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit_ld) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_ld) begin
            r_out_neuron <= IDX_W'(r_cnt);
            r_out_act    <= act;
            r_out_fin    <= emit_last;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.neuron     = r_out_neuron;
    assign o_out.activation = r_out_act;
    assign o_out.final_res  = r_out_fin;
endmodule

[hdl/dense_relu_layer.sv]
// channel   dir  handshake      payload
// i_in      in   valid/ready    command, in_index, out_index, value, row_end
// o_out     out  valid/ready    neuron, activation, final_res
//
// Weight or bias write/add: the back end reads the entry, then writes it.
// Feed: one multiply-accumulate per cycle on one shared MAC.
// Row end: min(OUT_SIZE, 16) results, each an acc and bias read, then a load that waits for o_out.
// Reset is synchronous; it clears control and the accumulator valid bits;
// weight and bias stores are undefined until written. A front register and a
// two-entry queue take items while the back end or o_out stalls.
module dense_relu_layer #(
    parameter int IN_SIZE   = 16,
    parameter int OUT_SIZE  = 16,
    parameter int DATA_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dr_in_if.sink    i_in,
    dr_out_if.source o_out
);
    import dr_pkg::*;

    t_job fr_job;
    logic fr_vld;
    logic fr_rdy;
    t_job q_job;
    logic q_vld;
    logic q_rdy;

    dr_front #(
        .IN_SIZE  (IN_SIZE),
        .OUT_SIZE (OUT_SIZE)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_job     (fr_job),
        .o_job_vld (fr_vld),
        .i_job_rdy (fr_rdy)
    );

    dr_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (fr_job),
        .i_push_vld (fr_vld),
        .o_push_rdy (fr_rdy),
        .o_job      (q_job),
        .o_pop_vld  (q_vld),
        .i_pop_rdy  (q_rdy)
    );

    dr_back #(
        .IN_SIZE   (IN_SIZE),
        .OUT_SIZE  (OUT_SIZE),
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (q_job),
        .i_job_vld (q_vld),
        .o_job_rdy (q_rdy),
        .o_out     (o_out)
    );
endmodule
